/* design/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/crt_pkg.sv */
package crt_pkg;

  // fixed field widths of the command and result beats
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned MEMBERS_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_REG    = 2'd0,
    CMD_PASS   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_VIEW   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_DUP      = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // control part of the probe token that walks along the cell row
  typedef struct packed {
    logic active;
    logic link_mode;   // compare the link field instead of the key
    logic hit;
    logic free_seen;
  } tok_ctl_t;

  // write strobes broadcast to all cells
  typedef struct packed {
    logic we_key;
    logic we_link;
    logic set_valid;
    logic clr_valid;
  } wr_ctl_t;

endpackage

/* design/crt_cell.sv */
module crt_cell #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned SLOT     = 0,
  localparam int unsigned SW      = $clog2(ENTRIES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crt_pkg::wr_ctl_t     wr_ctl,
  input  logic [SW-1:0]        wr_slot,
  input  logic [KEY_BITS-1:0]  wr_key,
  input  logic [SW-1:0]        wr_link,
  input  crt_pkg::tok_ctl_t    tok_ctl_i,
  input  logic [KEY_BITS-1:0]  probe_key_i,
  input  logic [SW-1:0]        probe_link_i,
  input  logic [SW-1:0]        hit_slot_i,
  input  logic [SW-1:0]        free_slot_i,
  output crt_pkg::tok_ctl_t    tok_ctl_o,
  output logic [KEY_BITS-1:0]  probe_key_o,
  output logic [SW-1:0]        probe_link_o,
  output logic [SW-1:0]        hit_slot_o,
  output logic [SW-1:0]        free_slot_o,
  output logic [KEY_BITS-1:0]  key_o,
  output logic [SW-1:0]        link_o
);
  import crt_pkg::*;

  localparam logic [SW-1:0] MY_SLOT = SW'(SLOT);

  logic [KEY_BITS-1:0] key_r;
  logic [SW-1:0]       link_r;
  logic                valid_r;
  tok_ctl_t            tok_ctl_r;
  tok_ctl_t            tok_ctl_nxt;
  logic [KEY_BITS-1:0] probe_key_r;
  logic [SW-1:0]       probe_link_r;
  logic [SW-1:0]       hit_slot_r;
  logic [SW-1:0]       hit_slot_nxt;
  logic [SW-1:0]       free_slot_r;
  logic [SW-1:0]       free_slot_nxt;
  logic                sel;
  logic                match;

  assign sel = (wr_slot == MY_SLOT);

  // local compare against the passing token
  assign match = valid_r && (tok_ctl_i.link_mode ? (link_r == probe_link_i)
                                                 : (key_r == probe_key_i));

  always_comb begin
    tok_ctl_nxt           = tok_ctl_i;
    tok_ctl_nxt.hit       = tok_ctl_i.hit | match;
    tok_ctl_nxt.free_seen = tok_ctl_i.free_seen | ~valid_r;
    hit_slot_nxt          = tok_ctl_i.hit ? hit_slot_i : MY_SLOT;
    free_slot_nxt         = tok_ctl_i.free_seen ? free_slot_i : MY_SLOT;
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && wr_ctl.set_valid) begin
      valid_r <= 1'b1;
    end else if (sel && wr_ctl.clr_valid) begin
      valid_r <= 1'b0;
    end
    if (sel && wr_ctl.we_key) begin
      key_r <= wr_key;
    end
    if (sel && wr_ctl.we_link) begin
      link_r <= wr_link;
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_ctl_r <= '0;
    end else begin
      tok_ctl_r <= tok_ctl_nxt;
    end
    probe_key_r  <= probe_key_i;
    probe_link_r <= probe_link_i;
    hit_slot_r   <= hit_slot_nxt;
    free_slot_r  <= free_slot_nxt;
  end

  assign tok_ctl_o    = tok_ctl_r;
  assign probe_key_o  = probe_key_r;
  assign probe_link_o = probe_link_r;
  assign hit_slot_o   = hit_slot_r;
  assign free_slot_o  = free_slot_r;
  assign key_o        = key_r;
  assign link_o       = link_r;

endmodule

/* design/circular_rotation_table.sv */
// Round-robin ring of up to ENTRIES keyed members, kept in insertion order.
// Input stream: one beat per command (register, pass, remove, view) with a key.
// Output stream: one result beat per command, ENTRIES-bounded run of beats for
// a view of a non-empty ring; out_tlast marks the final beat of each command.
// Each slot lives in a cell of a row; a probe token walks the row one cell per
// cycle to find a key, the lowest free slot or the predecessor of a slot.
// Steps per command: pass moves the turn to its successor and reports that
// key; pass, remove and view on an empty ring are answered without a walk;
// register takes one walk of the row, plus a link step when the new
// member is linked behind the tail; remove takes one walk when the key is
// absent or the member is the last one, else a key walk, then a predecessor
// walk, a link step and a clear step; a view sends one beat per cycle while
// the receiver takes them.
// Only one command is worked on at a time, so the row walks set the cycles per
// command; in_tready rises again once the last result beat sits in the output
// register, so a new command is taken while that beat still waits.
// When the receiver stalls, the output register holds its beat, a view pauses
// and other commands wait with their result. Reset empties the ring at once
// (valid bits clear), no sweep.
module circular_rotation_table #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16,
  localparam int unsigned IN_W    = ((crt_pkg::CMD_W + KEY_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W   =
    ((crt_pkg::STATUS_W + KEY_BITS + crt_pkg::MEMBERS_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // cmd, member_key
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // status, reported_key, members
  output logic             out_tlast
);
  import crt_pkg::*;

  localparam int unsigned SW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_REG_LINK, S_RM_LINK, S_RM_CLR,
    S_PASS, S_PASS_KEY, S_VIEW, S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;
  logic [SW-1:0]       head_r, head_nxt;
  logic [SW-1:0]       tail_r, tail_nxt;
  logic [SW-1:0]       turn_r, turn_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SW-1:0]       rd_slot_r, rd_slot_nxt;
  logic [SW-1:0]       aux_slot_r, aux_slot_nxt;
  logic [CW-1:0]       walk_r, walk_nxt;
  tok_ctl_t            launch_r, launch_nxt;
  logic [KEY_BITS-1:0] probe_key_r, probe_key_nxt;
  logic [SW-1:0]       probe_link_r, probe_link_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [MEMBERS_W-1:0] out_members_r, out_members_nxt;
  logic                out_last_r, out_last_nxt;

  cmd_t                in_cmd;
  logic [KEY_BITS-1:0] in_key;
  logic                can_emit;
  logic                view_last;

  wr_ctl_t             wr_ctl;
  logic [SW-1:0]       wr_slot;
  logic [KEY_BITS-1:0] wr_key;
  logic [SW-1:0]       wr_link;

  tok_ctl_t            tok_ctl   [ENTRIES+1];
  logic [KEY_BITS-1:0] tok_key   [ENTRIES+1];
  logic [SW-1:0]       tok_link  [ENTRIES+1];
  logic [SW-1:0]       tok_hit   [ENTRIES+1];
  logic [SW-1:0]       tok_free  [ENTRIES+1];
  logic [KEY_BITS-1:0] cell_key  [ENTRIES];
  logic [SW-1:0]       cell_link [ENTRIES];
  logic [KEY_BITS-1:0] key_rd;
  logic [SW-1:0]       link_rd;

  assign in_cmd = cmd_t'(in_tdata[CMD_W-1:0]);
  assign in_key = in_tdata[CMD_W +: KEY_BITS];

  // token entry at the head of the row
  assign tok_ctl[0]  = launch_r;
  assign tok_key[0]  = probe_key_r;
  assign tok_link[0] = probe_link_r;
  assign tok_hit[0]  = '0;
  assign tok_free[0] = '0;

  // row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    crt_cell #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .SLOT     (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr_ctl       (wr_ctl),
      .wr_slot      (wr_slot),
      .wr_key       (wr_key),
      .wr_link      (wr_link),
      .tok_ctl_i    (tok_ctl[i]),
      .probe_key_i  (tok_key[i]),
      .probe_link_i (tok_link[i]),
      .hit_slot_i   (tok_hit[i]),
      .free_slot_i  (tok_free[i]),
      .tok_ctl_o    (tok_ctl[i+1]),
      .probe_key_o  (tok_key[i+1]),
      .probe_link_o (tok_link[i+1]),
      .hit_slot_o   (tok_hit[i+1]),
      .free_slot_o  (tok_free[i+1]),
      .key_o        (cell_key[i]),
      .link_o       (cell_link[i])
    );
  end

  // single read port over the row
  assign key_rd  = cell_key[rd_slot_r];
  assign link_rd = cell_link[rd_slot_r];

  assign can_emit  = !out_tvalid_r || out_tready;
  assign view_last = (walk_r == count_r - CW'(1));

  // command sequencer
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    res_status_nxt  = res_status_r;
    res_key_nxt     = res_key_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    turn_nxt        = turn_r;
    count_nxt       = count_r;
    rd_slot_nxt     = rd_slot_r;
    aux_slot_nxt    = aux_slot_r;
    walk_nxt        = walk_r;
    launch_nxt      = '0;
    probe_key_nxt   = probe_key_r;
    probe_link_nxt  = probe_link_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_key_nxt     = out_key_r;
    out_members_nxt = out_members_r;
    out_last_nxt    = out_last_r;
    wr_ctl          = '0;
    wr_slot         = rd_slot_r;
    wr_key          = res_key_r;
    wr_link         = link_rd;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_cmd;
          res_key_nxt    = in_key;
          res_status_nxt = ST_OK;
          probe_key_nxt  = in_key;
          case (in_cmd)
            CMD_REG: begin
              launch_nxt.active = 1'b1;
              state_nxt         = S_SEARCH;
            end
            CMD_PASS: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                res_key_nxt    = '0;
                state_nxt      = S_EMIT;
              end else begin
                rd_slot_nxt = turn_r;
                state_nxt   = S_PASS;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_EMIT;
              end else begin
                launch_nxt.active = 1'b1;
                state_nxt         = S_SEARCH;
              end
            end
            default: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                res_key_nxt    = '0;
                state_nxt      = S_EMIT;
              end else begin
                rd_slot_nxt = turn_r;
                walk_nxt    = '0;
                state_nxt   = S_VIEW;
              end
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (tok_ctl[ENTRIES].active) begin
          if (cmd_r == CMD_REG) begin
            if (tok_ctl[ENTRIES].hit) begin
              res_status_nxt = ST_DUP;
              state_nxt      = S_EMIT;
            end else if (count_r >= CW'(ENTRIES)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_EMIT;
            end else begin
              // new slot closes onto the head, or onto itself when alone
              wr_ctl.we_key    = 1'b1;
              wr_ctl.we_link   = 1'b1;
              wr_ctl.set_valid = 1'b1;
              wr_slot          = tok_free[ENTRIES];
              wr_link          = (count_r == '0) ? tok_free[ENTRIES] : head_r;
              count_nxt        = count_r + CW'(1);
              aux_slot_nxt     = tok_free[ENTRIES];
              if (count_r == '0) begin
                head_nxt  = tok_free[ENTRIES];
                tail_nxt  = tok_free[ENTRIES];
                turn_nxt  = tok_free[ENTRIES];
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_REG_LINK;
              end
            end
          end else if (!tok_ctl[ENTRIES].link_mode) begin
            if (!tok_ctl[ENTRIES].hit) begin
              res_status_nxt = ST_NOTFOUND;
              state_nxt      = S_EMIT;
            end else if (count_r == CW'(1)) begin
              wr_ctl.clr_valid = 1'b1;
              wr_slot          = tok_hit[ENTRIES];
              head_nxt         = '0;
              tail_nxt         = '0;
              turn_nxt         = '0;
              count_nxt        = '0;
              state_nxt        = S_EMIT;
            end else begin
              // second walk looks for the slot linking to the victim
              rd_slot_nxt          = tok_hit[ENTRIES];
              probe_link_nxt       = tok_hit[ENTRIES];
              launch_nxt.active    = 1'b1;
              launch_nxt.link_mode = 1'b1;
            end
          end else begin
            aux_slot_nxt = tok_hit[ENTRIES];
            state_nxt    = S_RM_LINK;
          end
        end
      end

      S_REG_LINK: begin
        wr_ctl.we_link = 1'b1;
        wr_slot        = tail_r;
        wr_link        = aux_slot_r;
        tail_nxt       = aux_slot_r;
        state_nxt      = S_EMIT;
      end

      S_RM_LINK: begin
        // predecessor skips the victim; rd_slot_r points at the victim
        wr_ctl.we_link = 1'b1;
        wr_slot        = aux_slot_r;
        wr_link        = link_rd;
        if (rd_slot_r == head_r) begin
          head_nxt = link_rd;
        end
        if (rd_slot_r == tail_r) begin
          tail_nxt = aux_slot_r;
        end
        if (rd_slot_r == turn_r) begin
          turn_nxt = link_rd;
        end
        state_nxt = S_RM_CLR;
      end

      S_RM_CLR: begin
        wr_ctl.clr_valid = 1'b1;
        wr_slot          = rd_slot_r;
        count_nxt        = count_r - CW'(1);
        state_nxt        = S_EMIT;
      end

      S_PASS: begin
        turn_nxt    = link_rd;
        rd_slot_nxt = link_rd;
        state_nxt   = S_PASS_KEY;
      end

      S_PASS_KEY: begin
        res_key_nxt = key_rd;
        state_nxt   = S_EMIT;
      end

      S_VIEW: begin
        if (can_emit) begin
          out_tvalid_nxt  = 1'b1;
          out_status_nxt  = ST_OK;
          out_key_nxt     = key_rd;
          out_members_nxt = MEMBERS_W'(count_r);
          out_last_nxt    = view_last;
          rd_slot_nxt     = link_rd;
          walk_nxt        = walk_r + CW'(1);
          if (view_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (can_emit) begin
          out_tvalid_nxt  = 1'b1;
          out_status_nxt  = res_status_r;
          out_key_nxt     = res_key_r;
          out_members_nxt = MEMBERS_W'(count_r);
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      turn_r       <= '0;
      count_r      <= '0;
      launch_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      turn_r       <= turn_nxt;
      count_r      <= count_nxt;
      launch_r     <= launch_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r         <= cmd_nxt;
    res_status_r  <= res_status_nxt;
    res_key_r     <= res_key_nxt;
    rd_slot_r     <= rd_slot_nxt;
    aux_slot_r    <= aux_slot_nxt;
    walk_r        <= walk_nxt;
    probe_key_r   <= probe_key_nxt;
    probe_link_r  <= probe_link_nxt;
    out_status_r  <= out_status_nxt;
    out_key_r     <= out_key_nxt;
    out_members_r <= out_members_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_members_r, out_key_r, out_status_r});
  assign out_tlast  = out_last_r;

endmodule

/* design/crt_checker.sv */
`include "assert_macros.svh"

module crt_checker #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16,
  localparam int unsigned IN_W    = ((crt_pkg::CMD_W + KEY_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W   =
    ((crt_pkg::STATUS_W + KEY_BITS + crt_pkg::MEMBERS_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,   // cmd, member_key
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,  // status, reported_key, members
  input logic             out_tlast
);
  import crt_pkg::*;

  logic [STATUS_W-1:0]  st_f;
  logic [MEMBERS_W-1:0] members_f;
  logic                 in_beat;
  logic                 out_stall;
  logic [OUT_W:0]       out_beat;

  assign st_f      = out_tdata[STATUS_W-1:0];
  assign members_f = out_tdata[STATUS_W + KEY_BITS +: MEMBERS_W];
  assign in_beat   = in_tvalid && in_tready && (in_tdata[0] || !in_tdata[0]);
  assign out_stall = out_tvalid && !out_tready;
  assign out_beat  = {out_tlast, out_tdata};

  // output register comes out of reset empty
  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid, "result beat right after reset")

  // one command at a time: the port closes after each accepted beat
  `ASSERT_CLK(a_one_cmd, clk, rst_n, in_beat |=> !in_tready, "second command taken early")

  // status code stays within the defined set
  `ASSERT_CLK(a_status, clk, rst_n, out_tvalid |-> (st_f <= ST_FULL), "undefined status code")

  // member count never exceeds the table size
  `ASSERT_CLK(a_members, clk, rst_n, out_tvalid |-> (32'(members_f) <= ENTRIES), "count too high")

  // a stalled result beat holds
  `ASSERT_CLK(a_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_beat), "beat not held")

endmodule

bind circular_rotation_table crt_checker #(
  .ENTRIES  (ENTRIES),
  .KEY_BITS (KEY_BITS)
) u_crt_checker (.*);

/* tb/circular_rotation_table_tb.sv */
`timescale 1ns / 1ps

module circular_rotation_table_tb;
  import crt_pkg::*;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned KEY_BITS    = 16;
  localparam int unsigned IN_W        = ((CMD_W + KEY_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((STATUS_W + KEY_BITS + MEMBERS_W + 7) / 8) * 8;
  localparam int unsigned PHASE_ITEMS = 129;
  localparam int unsigned POOL_SIZE   = 20;
  localparam int unsigned MODE_SPAN   = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 2 * ENTRIES + 16;
  // ~410 commands, each up to 16 beats behind a receiver idling 85 percent of
  // the time, plus the long hold-off, must all finish before this watchdog limit
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    cmd_t                cmd;
    logic [KEY_BITS-1:0] key;
  } command_t;

  typedef struct {
    status_t              status;
    logic [KEY_BITS-1:0]  key;
    logic [MEMBERS_W-1:0] members;
    logic                 last;
  } ring_beat_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // cmd, member_key
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // status, reported_key, members
  logic             out_tlast;

  // beat fields as seen on the result port
  logic [STATUS_W-1:0]  got_status;
  logic [KEY_BITS-1:0]  got_key;
  logic [MEMBERS_W-1:0] got_members;

  assign got_status  = out_tdata[STATUS_W-1:0];
  assign got_key     = out_tdata[STATUS_W +: KEY_BITS];
  assign got_members = out_tdata[STATUS_W+KEY_BITS +: MEMBERS_W];

  command_t   command_q[$];
  command_t   offered;
  ring_beat_t ring_beats_due[$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  logic        hold_start  = 1'b0;

  // shadow copy of the ring
  logic [KEY_BITS-1:0] ring_key  [ENTRIES];
  int unsigned         ring_next [ENTRIES];
  bit                  ring_used [ENTRIES];
  int unsigned         head_idx   = 0;
  int unsigned         tail_idx   = 0;
  int unsigned         turn_idx   = 0;
  int unsigned         member_cnt = 0;

  circular_rotation_table #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void expect_beat(status_t st, logic [KEY_BITS-1:0] key, bit last);
    ring_beat_t b;
    b.status  = st;
    b.key     = key;
    b.members = MEMBERS_W'(member_cnt);
    b.last    = last;
    ring_beats_due.push_back(b);
  endfunction

  // walk from the head, ENTRIES when absent
  function automatic int unsigned find_slot(logic [KEY_BITS-1:0] key);
    int unsigned s;
    s = head_idx;
    for (int i = 0; i < member_cnt; i++) begin
      if (ring_used[s] && ring_key[s] == key) return s;
      s = ring_next[s];
    end
    return ENTRIES;
  endfunction

  function automatic status_t enroll(logic [KEY_BITS-1:0] key);
    int unsigned s;
    // duplicate check wins over full
    if (member_cnt > 0 && find_slot(key) < ENTRIES) return ST_DUP;
    if (member_cnt >= ENTRIES) return ST_FULL;
    s = 0;
    while (s < ENTRIES && ring_used[s]) s++;
    ring_key[s]  = key;
    ring_used[s] = 1'b1;
    if (member_cnt == 0) begin
      ring_next[s] = s;
      head_idx     = s;
      tail_idx     = s;
      turn_idx     = s;
    end else begin
      ring_next[tail_idx] = s;
      ring_next[s]        = head_idx;
      tail_idx            = s;
    end
    member_cnt++;
    return ST_OK;
  endfunction

  function automatic status_t retire(logic [KEY_BITS-1:0] key);
    int unsigned s;
    int unsigned prev;
    int unsigned succ;
    if (member_cnt == 0) return ST_EMPTY;
    s = find_slot(key);
    if (s >= ENTRIES) return ST_NOTFOUND;
    if (member_cnt == 1) begin
      ring_used[s] = 1'b0;
      head_idx     = 0;
      tail_idx     = 0;
      turn_idx     = 0;
      member_cnt   = 0;
      return ST_OK;
    end
    // predecessor search starts at the tail
    prev = tail_idx;
    for (int i = 0; i < member_cnt; i++) begin
      if (ring_next[prev] == s) break;
      prev = ring_next[prev];
    end
    succ            = ring_next[s];
    ring_next[prev] = succ;
    if (s == head_idx) head_idx = succ;
    if (s == tail_idx) tail_idx = prev;
    if (s == turn_idx) turn_idx = succ;
    ring_used[s] = 1'b0;
    member_cnt--;
    return ST_OK;
  endfunction

  // expected beats of one accepted command
  function automatic void predict_ring(command_t c);
    status_t     st;
    int unsigned s;
    case (c.cmd)
      CMD_REG: begin
        st = enroll(c.key);
        expect_beat(st, c.key, 1'b1);
      end
      CMD_PASS: begin
        if (member_cnt == 0) begin
          expect_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          turn_idx = ring_next[turn_idx];
          expect_beat(ST_OK, ring_key[turn_idx], 1'b1);
        end
      end
      CMD_REMOVE: begin
        st = retire(c.key);
        expect_beat(st, c.key, 1'b1);
      end
      default: begin
        if (member_cnt == 0) begin
          expect_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          s = turn_idx;
          for (int i = 0; i < member_cnt; i++) begin
            expect_beat(ST_OK, ring_key[s], (i + 1) == member_cnt);
            s = ring_next[s];
          end
        end
      end
    endcase
  endfunction

  function automatic void enqueue(cmd_t cmd, logic [KEY_BITS-1:0] key);
    command_t c;
    c.cmd = cmd;
    c.key = key;
    command_q.push_back(c);
  endfunction

  // empty-ring answers, key extremes, duplicates, turn/head/tail removal
  function automatic void queue_directed();
    enqueue(CMD_PASS,   16'h0000);
    enqueue(CMD_REMOVE, 16'h1234);
    enqueue(CMD_VIEW,   16'hffff);
    enqueue(CMD_REG,    16'h0000);
    enqueue(CMD_REG,    16'hffff);
    enqueue(CMD_REG,    16'h0000);
    enqueue(CMD_REG,    16'ha5a5);
    enqueue(CMD_VIEW,   16'h0000);
    enqueue(CMD_PASS,   16'h0000);
    enqueue(CMD_REMOVE, 16'hffff);
    enqueue(CMD_REMOVE, 16'h5a5a);
    enqueue(CMD_VIEW,   16'h0000);
    enqueue(CMD_REMOVE, 16'h0000);
    enqueue(CMD_REMOVE, 16'ha5a5);
    enqueue(CMD_PASS,   16'hffff);
    enqueue(CMD_VIEW,   16'h0000);
    enqueue(CMD_REG,    16'h5a5a);
    enqueue(CMD_REG,    16'h0001);
    enqueue(CMD_REG,    16'h8000);
    enqueue(CMD_REMOVE, 16'h8000);
    enqueue(CMD_REG,    16'h1111);
    enqueue(CMD_PASS,   16'h0000);
    enqueue(CMD_VIEW,   16'h0000);
  endfunction

  // alternating fill and drain stretches over a small key pool so that the
  // table runs full, duplicates hit and removes find their keys
  function automatic void queue_random(int unsigned n);
    logic [KEY_BITS-1:0] pool [POOL_SIZE];
    command_t            c;
    int unsigned         pick;
    int unsigned         cursor;
    bit                  filling;
    for (int p = 0; p < POOL_SIZE; p++) pool[p] = KEY_BITS'($urandom);
    pool[0] = '0;
    pool[1] = '1;
    cursor  = $urandom_range(0, POOL_SIZE - 1);
    filling = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % MODE_SPAN == 0) filling = ((i / MODE_SPAN) % 2 == 0);
      pick = $urandom_range(0, 99);
      if (filling)
        c.cmd = pick < 65 ? CMD_REG : pick < 77 ? CMD_PASS : pick < 87 ? CMD_REMOVE : CMD_VIEW;
      else
        c.cmd = pick < 15 ? CMD_REG : pick < 30 ? CMD_PASS : pick < 82 ? CMD_REMOVE : CMD_VIEW;
      pick  = $urandom_range(0, 99);
      c.key = KEY_BITS'($urandom);
      if (c.cmd == CMD_REG && filling && pick < 85) begin
        c.key  = pool[cursor];
        cursor = (cursor + 1) % POOL_SIZE;
      end else if ((c.cmd == CMD_REG || c.cmd == CMD_REMOVE) && pick < 85) begin
        c.key = pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      command_q.push_back(c);
    end
  endfunction

  // sender: predicts on each accepted beat, then offers the next one
  always @(posedge clk) begin : sender
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) predict_ring(offered);
      if (!in_tvalid || in_tready) begin
        if (command_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          offered = command_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'({offered.key, offered.cmd});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver: checks each accepted result beat against the oldest expectation
  always @(posedge clk) begin : receiver
    ring_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (ring_beats_due.size() == 0) begin
          note_error($sformatf("unexpected beat: status %0d key %h members %0d last %b",
                               got_status, got_key, got_members, out_tlast));
        end else begin
          want = ring_beats_due.pop_front();
          if (got_status !== want.status || got_key !== want.key ||
              got_members !== want.members || out_tlast !== want.last)
            note_error($sformatf({"beat mismatch: expected status %0d key %h members %0d ",
                                  "last %b, got status %0d key %h members %0d last %b"},
                                 want.status, want.key, want.members, want.last,
                                 got_status, got_key, got_members, out_tlast));
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_rotation_table regression: fail");
      $finish;
    end
  end

  task automatic wait_sender_idle();
    while (command_q.size() != 0 || in_tvalid) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n       <= 1'b1;
    tx_idle_pct <= 36;
    rx_idle_pct <= 85;
    queue_directed();
    queue_random(PHASE_ITEMS);
    wait_sender_idle();

    tx_idle_pct <= 85;
    rx_idle_pct <= 36;
    queue_random(PHASE_ITEMS);
    wait_sender_idle();

    // no idling, with a long receiver stall while commands keep coming
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    queue_random(PHASE_ITEMS);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_sender_idle();

    while (ring_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && ring_beats_due.size() == 0) begin
      $display("circular_rotation_table regression: pass");
    end else begin
      $display("circular_rotation_table regression: fail");
    end
    $finish;
  end

endmodule
